// ----- rtl/core/afrv_pkg.sv -----
`default_nettype none

package afrv_pkg;

   localparam int NUM_WORDS     = 4;
   localparam int WORD_W        = 32;
   localparam int SAMPLE_W      = 16;
   localparam int TRIG_W        = 4;
   localparam int CHAN_W        = 5;
   localparam int COUNT_W       = 3;
   localparam int FRAME_COUNT_W = 4;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 5;

   // result word layout
   localparam int CYCLE_BIT = 31;
   localparam int TRIG_LSB  = 25;
   localparam int CHAN_LSB  = 20;

   localparam logic [FRAME_COUNT_W-1:0] STARTUP_DISCARD = 4'd8;
   localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_MAX = 4'd15;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_CHANNEL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_COUNT      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXP_CHANNEL_0   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXP_CHANNEL_1   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXP_CHANNEL_2   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXP_CHANNEL_3   = 3'd6;

   typedef struct packed {
      logic                passed;
      logic                bad_cycle;
      logic                bad_trigger;
      logic                bad_channel;
      logic [SAMPLE_W-1:0] sample;
   } lane_result_type;

   typedef struct packed {
      logic                               dropped;
      logic                               frame_ok;
      logic [NUM_WORDS-1:0][SAMPLE_W-1:0] sample;
      logic [COUNT_W-1:0]                 passed_count;
      logic [COUNT_W-1:0]                 bad_cycle_count;
      logic [COUNT_W-1:0]                 bad_trigger_count;
      logic [COUNT_W-1:0]                 bad_channel_count;
   } frame_result_type;

endpackage

`default_nettype wire

// ----- rtl/core/adc_frame_result_validator.sv -----
`default_nettype none

// Checks one trigger-complete frame of four converter result words per request.
// Each of min(SLOTS, 4) lanes tests its word for the cycle bit, the trigger field
// and the expected channel; a merge stage counts the outcomes and releases the
// 16-bit samples only when every checked slot passed. The first frames after
// reset, while the saturating frame counter stays below the startup window, come
// out with only dropped set. With enable clear a request is consumed without a
// response and the frame counter holds. Requests are taken every cycle while the
// skid register is empty; responses leave the output register, and the skid
// register keeps req_ready high for one more request while rsp_ready is low.
// Write registers via csr_we/csr_index/csr_wdata only while idle; not enforced.
module adc_frame_result_validator #(
   parameter int SLOTS = 4
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [afrv_pkg::WORD_W-1:0]       req_word_0,
   input  logic [afrv_pkg::WORD_W-1:0]       req_word_1,
   input  logic [afrv_pkg::WORD_W-1:0]       req_word_2,
   input  logic [afrv_pkg::WORD_W-1:0]       req_word_3,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_dropped,
   output logic                              rsp_frame_ok,
   output logic [afrv_pkg::SAMPLE_W-1:0]     rsp_sample_0,
   output logic [afrv_pkg::SAMPLE_W-1:0]     rsp_sample_1,
   output logic [afrv_pkg::SAMPLE_W-1:0]     rsp_sample_2,
   output logic [afrv_pkg::SAMPLE_W-1:0]     rsp_sample_3,
   output logic [afrv_pkg::COUNT_W-1:0]      rsp_passed_count,
   output logic [afrv_pkg::COUNT_W-1:0]      rsp_bad_cycle_count,
   output logic [afrv_pkg::COUNT_W-1:0]      rsp_bad_trigger_count,
   output logic [afrv_pkg::COUNT_W-1:0]      rsp_bad_channel_count,

   input  logic                              csr_we,
   input  logic [afrv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [afrv_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import afrv_pkg::*;

   localparam int LANES = (SLOTS < NUM_WORDS) ? SLOTS : NUM_WORDS;

   // configuration
   logic                              enable_ff;
   logic [TRIG_W-1:0]                 trigger_channel_ff;
   logic [COUNT_W-1:0]                slot_count_ff;
   logic [NUM_WORDS-1:0][CHAN_W-1:0]  exp_channel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff          <= 1'b0;
         trigger_channel_ff <= '0;
         slot_count_ff      <= COUNT_W'(1);
         exp_channel_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:          enable_ff          <= csr_wdata[0];
            CSR_TRIGGER_CHANNEL: trigger_channel_ff <= csr_wdata[TRIG_W-1:0];
            CSR_SLOT_COUNT:      slot_count_ff      <= csr_wdata[COUNT_W-1:0];
            CSR_EXP_CHANNEL_0:   exp_channel_ff[0]  <= csr_wdata[CHAN_W-1:0];
            CSR_EXP_CHANNEL_1:   exp_channel_ff[1]  <= csr_wdata[CHAN_W-1:0];
            CSR_EXP_CHANNEL_2:   exp_channel_ff[2]  <= csr_wdata[CHAN_W-1:0];
            CSR_EXP_CHANNEL_3:   exp_channel_ff[3]  <= csr_wdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   // request handshake and startup counter
   logic                     req_fire;
   logic                     frame_new;
   logic [FRAME_COUNT_W-1:0] frame_counter_ff;
   logic [FRAME_COUNT_W-1:0] frame_counter_in;
   logic                     dropped;

   assign req_fire  = req_valid && req_ready;
   assign frame_new = req_fire && enable_ff;

   assign frame_counter_in = (frame_counter_ff == FRAME_COUNT_MAX) ? frame_counter_ff
                             : frame_counter_ff + FRAME_COUNT_W'(1);
   assign dropped = frame_counter_in < STARTUP_DISCARD;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_counter_ff <= '0;
      end else if (frame_new) begin
         frame_counter_ff <= frame_counter_in;
      end
   end

   // lanes
   logic [NUM_WORDS-1:0][WORD_W-1:0] words;
   lane_result_type [LANES-1:0]      lane_res;
   frame_result_type                 frame_res;

   assign words = {req_word_3, req_word_2, req_word_1, req_word_0};

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      afrv_lane u_lane (
         .check_en         (slot_count_ff > COUNT_W'(g)),
         .word             (words[g]),
         .trigger_channel  (trigger_channel_ff),
         .expected_channel (exp_channel_ff[g]),
         .result           (lane_res[g])
      );
   end

   afrv_merge #(
      .LANES (LANES)
   ) u_merge (
      .lane_res   (lane_res),
      .dropped    (dropped),
      .slot_count (slot_count_ff),
      .result     (frame_res)
   );

   // output register plus skid register
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   frame_result_type rsp_data_ff;
   frame_result_type rsp_data_in;
   logic             skid_valid_ff;
   logic             skid_valid_in;
   frame_result_type skid_data_ff;
   frame_result_type skid_data_in;
   logic             rsp_fire;

   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign req_ready = !skid_valid_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no request is taken while the skid register is full
         if (rsp_fire) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (frame_new) begin
         if (!rsp_valid_ff || rsp_fire) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = frame_res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = frame_res;
         end
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_dropped           = rsp_data_ff.dropped;
   assign rsp_frame_ok          = rsp_data_ff.frame_ok;
   assign rsp_sample_0          = rsp_data_ff.sample[0];
   assign rsp_sample_1          = rsp_data_ff.sample[1];
   assign rsp_sample_2          = rsp_data_ff.sample[2];
   assign rsp_sample_3          = rsp_data_ff.sample[3];
   assign rsp_passed_count      = rsp_data_ff.passed_count;
   assign rsp_bad_cycle_count   = rsp_data_ff.bad_cycle_count;
   assign rsp_bad_trigger_count = rsp_data_ff.bad_trigger_count;
   assign rsp_bad_channel_count = rsp_data_ff.bad_channel_count;

   // skid register is only occupied behind a waiting response
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // a request taken while disabled must not create a response
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !enable_ff && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("response created for a request taken while disabled");

   // startup counter only moves forward
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (frame_counter_ff >= $past(frame_counter_ff)))
      else $error("frame counter went backward");

   // an accepted frame carries no failure counts
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_ok) |->
         (!rsp_data_ff.dropped && rsp_data_ff.bad_cycle_count == '0 &&
          rsp_data_ff.bad_trigger_count == '0 && rsp_data_ff.bad_channel_count == '0))
      else $error("accepted frame reports failures");

   // a dropped frame carries nothing else
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.dropped) |->
         (!rsp_data_ff.frame_ok && rsp_data_ff.passed_count == '0 &&
          rsp_data_ff.bad_cycle_count == '0))
      else $error("dropped frame carries check results");

endmodule

`default_nettype wire

// ----- rtl/core/afrv_lane.sv -----
`default_nettype none

module afrv_lane (
   input  logic                          check_en,
   input  logic [afrv_pkg::WORD_W-1:0]   word,
   input  logic [afrv_pkg::TRIG_W-1:0]   trigger_channel,
   input  logic [afrv_pkg::CHAN_W-1:0]   expected_channel,
   output afrv_pkg::lane_result_type     result
);
   import afrv_pkg::*;

   always_comb begin
      result = '0;
      if (check_en) begin
         result.sample = word[SAMPLE_W-1:0];
         // first failing check decides the category
         priority if (!word[CYCLE_BIT]) begin
            result.bad_cycle = 1'b1;
         end else if (word[TRIG_LSB +: TRIG_W] != trigger_channel) begin
            result.bad_trigger = 1'b1;
         end else if (word[CHAN_LSB +: CHAN_W] != expected_channel) begin
            result.bad_channel = 1'b1;
         end else begin
            result.passed = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/afrv_merge.sv -----
`default_nettype none

module afrv_merge #(
   parameter int LANES = 4
) (
   input  afrv_pkg::lane_result_type [LANES-1:0] lane_res,
   input  logic                                  dropped,
   input  logic [afrv_pkg::COUNT_W-1:0]          slot_count,
   output afrv_pkg::frame_result_type            result
);
   import afrv_pkg::*;

   logic [COUNT_W-1:0] passed_sum;
   logic [COUNT_W-1:0] cycle_sum;
   logic [COUNT_W-1:0] trigger_sum;
   logic [COUNT_W-1:0] channel_sum;
   logic               frame_ok;

   always_comb begin
      passed_sum  = '0;
      cycle_sum   = '0;
      trigger_sum = '0;
      channel_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         passed_sum  = passed_sum  + COUNT_W'(lane_res[i].passed);
         cycle_sum   = cycle_sum   + COUNT_W'(lane_res[i].bad_cycle);
         trigger_sum = trigger_sum + COUNT_W'(lane_res[i].bad_trigger);
         channel_sum = channel_sum + COUNT_W'(lane_res[i].bad_channel);
      end
   end

   // a slot count above the lanes can never be matched by passed_sum
   assign frame_ok = (slot_count != '0) && (passed_sum == slot_count);

   always_comb begin
      result = '0;
      if (dropped) begin
         result.dropped = 1'b1;
      end else begin
         result.frame_ok          = frame_ok;
         result.passed_count      = passed_sum;
         result.bad_cycle_count   = cycle_sum;
         result.bad_trigger_count = trigger_sum;
         result.bad_channel_count = channel_sum;
         if (frame_ok) begin
            for (int i = 0; i < LANES; i++) begin
               result.sample[i] = lane_res[i].sample;
            end
         end
      end
   end

endmodule

`default_nettype wire
